FILE: rtl/ckf_pkg.sv
// shared types and codes for the three-axis constant-velocity track filter
`timescale 1ns / 1ps
`default_nettype none
package ckf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_MUL, ST_ACC, ST_PCOV, ST_GATE, ST_DIV, ST_CNT, ST_OUT
  } st_t;

  typedef enum logic [3:0] {
    U_DV, U_DC, U_DDV, U_PP, U_SQ, U_LIM, U_KVR, U_KPR, U_KVC, U_KPC, U_KPP, U_AH
  } uop_t;

  localparam logic [1:0] CMD_MEAS  = 2'd0;
  localparam logic [1:0] CMD_COAST = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [2:0] EV_CORRECTED = 3'd0;
  localparam logic [2:0] EV_REJECTED  = 3'd1;
  localparam logic [2:0] EV_REINIT    = 3'd2;
  localparam logic [2:0] EV_COASTED   = 3'd3;
  localparam logic [2:0] EV_CLEARED   = 3'd4;
  localparam logic [2:0] EV_IGNORED   = 3'd5;

  localparam logic [1:0] MODE_LOST   = 2'd0;
  localparam logic [1:0] MODE_DETECT = 2'd1;
  localparam logic [1:0] MODE_TRACK  = 2'd2;

  localparam logic [2:0] REG_PPN  = 3'd0;
  localparam logic [2:0] REG_VPN  = 3'd1;
  localparam logic [2:0] REG_MN   = 3'd2;
  localparam logic [2:0] REG_JL   = 3'd3;
  localparam logic [2:0] REG_LL   = 3'd4;
  localparam logic [2:0] REG_THR  = 3'd5;
  localparam logic [2:0] REG_DTL  = 3'd6;
  localparam logic [2:0] REG_FDT  = 3'd7;

endpackage
`default_nettype wire

FILE: rtl/cv_kalman_track_filter_3d.sv
// top level of the three-axis constant-velocity track filter with gating
`timescale 1ns / 1ps
`default_nettype none
// throughput: one transaction in flight; the bit-serial gain divider run twice dominates
// a single 34x34 multiplier is shared by every product, each product passing through ST_MUL then ST_ACC
// reset: synchronous active-low rst_n restores the register defaults and clears the track
module cv_kalman_track_filter_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input transaction
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [175:0] in_tdata,   // meas_x, meas_y, meas_z, time_stamp[47:0], lead_time
  input  logic [1:0]   in_tuser,   // cmd
  // result transaction
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // pos_x/y/z, vel_x/y/z, ahead_x/y/z
  output logic [4:0]   out_tuser,  // track_mode[1:0], event_res[2:0]
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ckf_pkg::*;

  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647)       return 32'sh7FFFFFFF;
    else if (v < -70'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  // configuration registers
  logic [31:0] ppn_r, vpn_r, mn_r, jl_r, dtl_r, fdt_r;
  logic [7:0]  ll_r, thr_r;

  // track state
  logic signed [31:0] pos_r [3];
  logic signed [31:0] spd_r [3];
  logic signed [31:0] cp_r, cc_r, cv_r;
  logic               started_r;
  logic [1:0]         mode_r;
  logic [7:0]         hits_r, mis_r;
  logic [47:0]        prev_r;

  // captured transaction and working values
  logic [1:0]         cmd_r;
  logic signed [31:0] m_r [3];
  logic [47:0]        ts_r;
  logic [31:0]        lead_r;
  logic [31:0]        dt_r;
  logic signed [31:0] dv_r, dc_r, ddv_r;
  logic [65:0]        sum_r;
  logic [63:0]        lim_r;
  logic signed [31:0] kp_r, kv_r;
  logic signed [31:0] ah_r [3];
  logic [2:0]         ev_r;
  logic signed [67:0] prod_r;
  logic               sel_r;

  st_t                st_r, st_nxt;
  uop_t               uop_r, uop_nxt;
  logic [1:0]         ax_r, ax_nxt;

  logic               out_tvalid_r;
  logic [287:0]       out_data_r;
  logic [4:0]         out_user_r;

  // datapath helpers
  logic signed [32:0] res;
  logic        [32:0] res_abs;
  logic signed [31:0] t16, tf;
  logic [7:0]         mis_inc, hits_inc;
  logic [47:0]        diff;
  logic [31:0]        dt_sel;
  logic signed [33:0] s_val;
  logic               gate_fail;
  logic               out_load;
  logic               do_reinit, do_clear;
  logic signed [33:0] mul_a, mul_b;
  logic               div_start, div_done;
  logic signed [31:0] div_num, div_q;

  always_comb begin
    res      = 33'(m_r[ax_r]) - 33'(pos_r[ax_r]);
    res_abs  = res[32] ? 33'(-res) : 33'(res);
    t16      = sat32(70'(prod_r >>> 16));
    tf       = sat32(70'(prod_r >>> FRAC_BITS));
    mis_inc  = (mis_r == 8'hFF) ? mis_r : mis_r + 8'd1;
    hits_inc = (hits_r == 8'hFF) ? hits_r : hits_r + 8'd1;
    diff     = ts_r - prev_r;
    // step falls back when not positive or beyond the limit
    dt_sel   = (diff == '0 || diff[47] || diff > {16'd0, dtl_r}) ? fdt_r : diff[31:0];
    s_val    = 34'(cp_r) + $signed({2'b00, mn_r});
    gate_fail = sum_r > {2'b00, lim_r};
    out_load = (st_r == ST_OUT) && (!out_tvalid_r || out_tready);
  end

  // next state of the sequencer
  always_comb begin
    st_nxt  = st_r;
    uop_nxt = uop_r;
    ax_nxt  = ax_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_DEC;
      ST_DEC: begin
        if (started_r && (cmd_r == CMD_MEAS || cmd_r == CMD_COAST)) begin
          st_nxt = ST_MUL; uop_nxt = U_DV; ax_nxt = 2'd0;
        end else if (cmd_r == CMD_MEAS) begin
          st_nxt = ST_MUL; uop_nxt = U_AH; ax_nxt = 2'd0;
        end else if (cmd_r == CMD_RESET || !started_r) begin
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_MUL; uop_nxt = U_AH; ax_nxt = 2'd0;
        end
      end
      ST_MUL: st_nxt = ST_ACC;
      ST_ACC: begin
        st_nxt = ST_MUL;
        case (uop_r)
          U_DV:  uop_nxt = U_DC;
          U_DC:  uop_nxt = U_DDV;
          U_DDV: begin uop_nxt = U_PP; ax_nxt = 2'd0; end
          U_PP:  if (ax_r == 2'd2) st_nxt = ST_PCOV; else ax_nxt = ax_r + 2'd1;
          U_SQ:  if (ax_r == 2'd2) uop_nxt = U_LIM; else ax_nxt = ax_r + 2'd1;
          U_LIM: st_nxt = ST_GATE;
          U_KVR: uop_nxt = U_KPR;
          U_KPR: begin
            if (ax_r == 2'd2) uop_nxt = U_KVC;
            else begin uop_nxt = U_KVR; ax_nxt = ax_r + 2'd1; end
          end
          U_KVC: uop_nxt = U_KPC;
          U_KPC: uop_nxt = U_KPP;
          U_KPP: st_nxt = ST_CNT;
          U_AH:  if (ax_r == 2'd2) st_nxt = ST_OUT; else ax_nxt = ax_r + 2'd1;
          default: st_nxt = ST_OUT;
        endcase
      end
      ST_PCOV: begin
        if (cmd_r == CMD_MEAS) begin
          st_nxt = ST_MUL; uop_nxt = U_SQ; ax_nxt = 2'd0;
        end else if (mis_inc > ll_r) begin
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_MUL; uop_nxt = U_AH; ax_nxt = 2'd0;
        end
      end
      ST_GATE: begin
        if (gate_fail) begin
          st_nxt = ST_MUL; uop_nxt = U_AH; ax_nxt = 2'd0;
        end else if (s_val > 34'sd0) begin
          st_nxt = ST_DIV;
        end else begin
          st_nxt = ST_CNT;
        end
      end
      ST_DIV: if (div_done && sel_r) begin
        st_nxt = ST_MUL; uop_nxt = U_KVR; ax_nxt = 2'd0;
      end
      ST_CNT: begin st_nxt = ST_MUL; uop_nxt = U_AH; ax_nxt = 2'd0; end
      ST_OUT: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier operands, divider control
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    do_reinit = ((st_r == ST_DEC) && (cmd_r == CMD_MEAS) && !started_r) ||
                ((st_r == ST_GATE) && gate_fail && (mis_inc > ll_r));
    do_clear  = ((st_r == ST_DEC) && (cmd_r == CMD_RESET)) ||
                ((st_r == ST_PCOV) && (cmd_r == CMD_COAST) && (mis_inc > ll_r));
    div_start = ((st_r == ST_GATE) && !gate_fail && (s_val > 34'sd0)) ||
                ((st_r == ST_DIV) && div_done && !sel_r);
    div_num   = (st_r == ST_GATE) ? cp_r : cc_r;
    mul_a = $signed({2'b00, dt_r});
    mul_b = 34'(cv_r);
    case (uop_r)
      U_DV:  begin mul_a = $signed({2'b00, dt_r});   mul_b = 34'(cv_r); end
      U_DC:  begin mul_a = $signed({2'b00, dt_r});   mul_b = 34'(cc_r); end
      U_DDV: begin mul_a = $signed({2'b00, dt_r});   mul_b = 34'(dv_r); end
      U_PP:  begin mul_a = $signed({2'b00, dt_r});   mul_b = 34'(spd_r[ax_r]); end
      U_SQ:  begin mul_a = $signed({1'b0, res_abs}); mul_b = $signed({1'b0, res_abs}); end
      U_LIM: begin mul_a = $signed({2'b00, jl_r});   mul_b = $signed({2'b00, jl_r}); end
      U_KVR: begin mul_a = 34'(kv_r);                mul_b = 34'(res); end
      U_KPR: begin mul_a = 34'(kp_r);                mul_b = 34'(res); end
      U_KVC: begin mul_a = 34'(kv_r);                mul_b = 34'(cc_r); end
      U_KPC: begin mul_a = 34'(kp_r);                mul_b = 34'(cc_r); end
      U_KPP: begin mul_a = 34'(kp_r);                mul_b = 34'(cp_r); end
      U_AH:  begin mul_a = $signed({2'b00, lead_r}); mul_b = 34'(spd_r[ax_r]); end
      default: ;
    endcase
  end

  ckf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (s_val[32:0]),
    .done  (div_done),
    .quo   (div_q)
  );

  // control state and handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      uop_r        <= U_DV;
      ax_r         <= 2'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      uop_r <= uop_nxt;
      ax_r  <= ax_nxt;
      if (out_load)        out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // configuration writes, taken at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppn_r <= 32'd655;
      vpn_r <= 32'd65536;
      mn_r  <= 32'd3277;
      jl_r  <= 32'd32768;
      ll_r  <= 8'd10;
      thr_r <= 8'd5;
      dtl_r <= 32'd6554;
      fdt_r <= 32'd655;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PPN: ppn_r <= cfg_data;
        REG_VPN: vpn_r <= cfg_data;
        REG_MN:  mn_r  <= cfg_data;
        REG_JL:  jl_r  <= cfg_data;
        REG_LL:  ll_r  <= cfg_data[7:0];
        REG_THR: thr_r <= cfg_data[7:0];
        REG_DTL: dtl_r <= cfg_data;
        REG_FDT: fdt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload capture, working values and output register
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_tvalid) begin
      cmd_r  <= in_tuser;
      m_r[0] <= in_tdata[31:0];
      m_r[1] <= in_tdata[63:32];
      m_r[2] <= in_tdata[95:64];
      ts_r   <= in_tdata[143:96];
      lead_r <= in_tdata[175:144];
    end
    if (st_r == ST_MUL) prod_r <= mul_a * mul_b;
    if (out_load) begin
      out_data_r <= {started_r ? ah_r[2] : 32'sd0, started_r ? ah_r[1] : 32'sd0,
                     started_r ? ah_r[0] : 32'sd0, spd_r[2], spd_r[1], spd_r[0],
                     pos_r[2], pos_r[1], pos_r[0]};
      out_user_r <= {ev_r, mode_r};
    end
    case (st_r)
      ST_ACC: begin
        case (uop_r)
          U_AH:  ah_r[ax_r] <= sat32(70'(pos_r[ax_r]) + 70'(t16));
          U_SQ:  sum_r <= sum_r + {2'b00, prod_r[63:0]};
          U_LIM: lim_r <= prod_r[63:0];
          U_DV:  dv_r  <= t16;
          U_DC:  dc_r  <= t16;
          U_DDV: ddv_r <= t16;
          default: ;
        endcase
      end
      ST_PCOV: sum_r <= '0;
      ST_GATE: sel_r <= 1'b0;
      ST_DIV: begin
        if (div_done) begin
          if (!sel_r) begin kp_r <= div_q; sel_r <= 1'b1; end
          else kv_r <= div_q;
        end
      end
      default: ;
    endcase
  end

  // track state updates; clear and reinitialise take priority
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        spd_r[i] <= '0;
      end
      cp_r      <= ONE;
      cc_r      <= '0;
      cv_r      <= ONE;
      started_r <= 1'b0;
      mode_r    <= MODE_LOST;
      hits_r    <= '0;
      mis_r     <= '0;
      prev_r    <= '0;
      ev_r      <= EV_IGNORED;
    end else begin
      case (st_r)
        ST_DEC: begin
          if (started_r && (cmd_r == CMD_MEAS || cmd_r == CMD_COAST)) begin
            dt_r   <= dt_sel;
            prev_r <= ts_r;
          end
          if (cmd_r == CMD_MEAS)       ev_r <= EV_REINIT;
          else if (cmd_r == CMD_RESET) ev_r <= EV_CLEARED;
          else                         ev_r <= EV_IGNORED;
        end
        ST_ACC: begin
          case (uop_r)
            U_PP:  pos_r[ax_r] <= sat32(70'(pos_r[ax_r]) + 70'(t16));
            U_KVR: spd_r[ax_r] <= sat32(70'(spd_r[ax_r]) + 70'(tf));
            U_KPR: pos_r[ax_r] <= sat32(70'(pos_r[ax_r]) + 70'(tf));
            U_KVC: cv_r <= sat32(70'(cv_r) - 70'(tf));
            U_KPC: cc_r <= sat32(70'(cc_r) - 70'(tf));
            U_KPP: cp_r <= sat32(70'(cp_r) - 70'(tf));
            default: ;
          endcase
        end
        ST_PCOV: begin
          // finish the covariance predict from the three saturated products
          cp_r <= sat32(70'(cp_r) + 70'(dc_r) + 70'(dc_r) + 70'(ddv_r) +
                        70'($signed({1'b0, ppn_r})));
          cc_r <= sat32(70'(cc_r) + 70'(dv_r));
          cv_r <= sat32(70'(cv_r) + 70'($signed({1'b0, vpn_r})));
          if (cmd_r == CMD_COAST) begin
            mis_r <= mis_inc;
            if (mode_r == MODE_TRACK) mode_r <= MODE_DETECT;
            ev_r <= (mis_inc > ll_r) ? EV_CLEARED : EV_COASTED;
          end
        end
        ST_GATE: begin
          if (gate_fail) begin
            mis_r <= mis_inc;
            ev_r  <= (mis_inc > ll_r) ? EV_REINIT : EV_REJECTED;
          end else begin
            ev_r <= EV_CORRECTED;
          end
        end
        ST_CNT: begin
          hits_r <= hits_inc;
          mis_r  <= '0;
          mode_r <= (hits_inc >= thr_r) ? MODE_TRACK : MODE_DETECT;
        end
        default: ;
      endcase
      if (do_clear) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= '0;
          spd_r[i] <= '0;
        end
        cp_r      <= ONE;
        cc_r      <= '0;
        cv_r      <= ONE;
        started_r <= 1'b0;
        mode_r    <= MODE_LOST;
        hits_r    <= '0;
        mis_r     <= '0;
      end
      if (do_reinit) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= m_r[i];
          spd_r[i] <= '0;
        end
        cp_r      <= ONE;
        cc_r      <= '0;
        cv_r      <= ONE;
        started_r <= 1'b1;
        prev_r    <= ts_r;
        hits_r    <= 8'd1;
        mis_r     <= '0;
        mode_r    <= MODE_DETECT;
      end
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule
`default_nettype wire

FILE: rtl/ckf_div.sv
// radix-2 restoring divider for the gain quotients, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ckf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [32:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [33:0]   rem_r;
  logic [32:0]   den_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;
  logic signed [31:0] res_r;

  logic [31:0] mag;
  logic [34:0] rem_sh;
  logic        fits;
  logic        ovf_pos;
  logic        ovf_neg;

  always_comb begin
    mag     = num[31] ? 32'(-num) : 32'(num);
    rem_sh  = {rem_r, q_r[DW-1]};
    fits    = rem_sh >= {2'b00, den_r};
    ovf_pos = |q_r[DW-1:31];
    ovf_neg = (|q_r[DW-1:32]) || (q_r[31] && (|q_r[30:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= num[31];
        q_r    <= {mag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= fits ? 34'(rem_sh - {2'b00, den_r}) : rem_sh[33:0];
          q_r   <= {q_r[DW-2:0], fits};
          cnt_r <= cnt_r - 1'b1;
        end else begin
          // sign and saturate the truncated quotient
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (neg_r) res_r <= ovf_neg ? 32'sh80000000 : -$signed(q_r[31:0]);
          else       res_r <= ovf_pos ? 32'sh7FFFFFFF : $signed(q_r[31:0]);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = res_r;
endmodule
`default_nettype wire

FILE: rtl/ckf_checker.sv
// port-level checks on the result stream of the track filter, with bind
`timescale 1ns / 1ps
`default_nettype none
module ckf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [287:0] out_tdata,
  input logic [4:0]   out_tuser
);
  import ckf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_ev_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[4:2] <= EV_IGNORED)
    else $error("event code out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:2] == EV_CLEARED |->
      out_tuser[1:0] == MODE_LOST && out_tdata == '0)
    else $error("cleared track not at rest");

  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:2] == EV_REINIT |->
      out_tuser[1:0] == MODE_DETECT && out_tdata[191:96] == '0)
    else $error("reinitialised track not detecting with zero speed");
endmodule

bind cv_kalman_track_filter_3d ckf_checker u_ckf_checker (.*);
`default_nettype wire
